[sv/msg_pkg.sv]
// Shared constants, codes and types of the multi-axis step generator.
`timescale 1ns / 1ps

package msg_pkg;

    localparam int POS_BITS   = 24;
    localparam int IN_BITS    = 24;
    localparam int AXES       = 3;
    localparam int DELTA_BITS = 25;
    localparam int ACC_BITS   = DELTA_BITS + 1;
    localparam int DELAY_BITS = 16;
    localparam int CALC_BITS  = ((POS_BITS > IN_BITS) ? POS_BITS : IN_BITS) + 2;

    localparam int S_TDATA_BITS = 72;
    localparam int M_TDATA_BITS = 24;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [DELAY_BITS-1:0] DELAY_MAX = {DELAY_BITS{1'b1}};

    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CRUISE = 2'd2;

    localparam logic                  MODE_RESET   = 1'b1;
    localparam logic [DELAY_BITS-1:0] START_RESET  = 16'd1000;
    localparam logic [DELAY_BITS-1:0] CRUISE_RESET = 16'd100;

    typedef enum logic [1:0] {
        OP_MOVE   = 2'd0,
        OP_TICK   = 2'd1,
        OP_SETPOS = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef struct packed {
        logic do_move;
        logic do_tick;
        logic do_set;
        logic abs_mode;
    } lane_cmd_t;

    typedef struct packed {
        logic                  ok_move;
        logic                  ok_set;
        logic                  dir_pos;
        logic [DELTA_BITS-1:0] abs_delta;
        logic                  pulse;
    } lane_stat_t;

    typedef struct packed {
        logic [AXES-1:0]       dirs;
        logic [DELAY_BITS-1:0] delay;
        logic                  last;
        logic                  idle;
    } merge_res_t;

    typedef struct packed {
        logic                    last;
        logic [M_TDATA_BITS-1:0] data;
    } out_beat_t;

endpackage

[sv/multi_axis_step_generator.sv]
// Top level of the three-axis step pulse generator with a trapezoid delay ramp.
`timescale 1ns / 1ps

// The block takes one beat (start move, step tick or set position) in every clock
// cycle while s_tready is high and returns exactly one result beat per input beat,
// registered in the output register or in the skid register. Each axis has its own
// lane that checks the target, forms the delta and runs the Bresenham accumulator;
// a merge stage picks the step count, plans the ramp and keeps the delay. A two-entry
// output buffer keeps s_tready high while one result waits on the master side, so
// the rate is one beat per cycle as long as results are taken. Configuration is to
// be written only while no move is running and no result is pending (not enforced).

module multi_axis_step_generator
    import msg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [DELAY_BITS-1:0]   cfg_data,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // target_x [23:0], target_z [47:24], target_a [71:48]
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    // operation [1:0]
    input  logic [1:0]              s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // step_x [0], step_z [1], step_a [2], dir_x [3], dir_z [4], dir_a [5],
    // interval_delay [21:6], idle [22], rejected [23]
    output logic [M_TDATA_BITS-1:0] m_tdata,
    // last_step
    output logic                    m_tlast
);

    logic                  mode_reg, mode_next;
    logic [DELAY_BITS-1:0] start_reg, start_next;
    logic [DELAY_BITS-1:0] cruise_reg, cruise_next;

    logic                  accept;
    op_t                   op;
    lane_cmd_t             cmd;
    lane_stat_t            stat [AXES];
    logic [AXES-1:0]       ok_move;
    logic [AXES-1:0]       ok_set;
    logic [AXES-1:0]       pulses;
    logic                  move_ok;
    logic                  set_ok;
    logic                  active;
    logic [AXES-1:0]       dirs;
    logic [DELTA_BITS-1:0] total;
    logic [DELTA_BITS-1:0] seed;
    merge_res_t            res;
    logic                  rejected;
    out_beat_t             beat;
    out_beat_t             m_beat;

    always_comb
    begin
        mode_next   = mode_reg;
        start_next  = start_reg;
        cruise_next = cruise_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:   mode_next   = cfg_data[0];
                CFG_START:  start_next  = cfg_data;
                CFG_CRUISE: cruise_next = cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RESET;
            start_reg  <= START_RESET;
            cruise_reg <= CRUISE_RESET;
        end
        else
        begin
            mode_reg   <= mode_next;
            start_reg  <= start_next;
            cruise_reg <= cruise_next;
        end
    end

    assign accept = s_tvalid && s_tready;
    assign op     = op_t'(s_tuser);

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            ok_move[i] = stat[i].ok_move;
            ok_set[i]  = stat[i].ok_set;
            pulses[i]  = stat[i].pulse;
        end
    end

    assign move_ok = &ok_move;
    assign set_ok  = &ok_set;

    assign cmd.abs_mode = mode_reg;
    assign cmd.do_move  = accept && (op == OP_MOVE) && !active && move_ok;
    assign cmd.do_tick  = accept && (op == OP_TICK) && active;
    assign cmd.do_set   = accept && (op == OP_SETPOS) && !active && set_ok;

    assign rejected = ((op == OP_MOVE) && (active || !move_ok))
                   || ((op == OP_SETPOS) && (active || !set_ok));

    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        msg_axis_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .target  (s_tdata[g*IN_BITS +: IN_BITS]),
            .dir_bit (dirs[g]),
            .total   (total),
            .seed    (seed),
            .stat    (stat[g])
        );
    end

    msg_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .do_move      (cmd.do_move),
        .do_tick      (cmd.do_tick),
        .stat         (stat),
        .start_delay  (start_reg),
        .cruise_delay (cruise_reg),
        .active       (active),
        .dirs         (dirs),
        .total        (total),
        .seed         (seed),
        .res          (res)
    );

    assign beat.last = res.last;
    assign beat.data = {rejected, res.idle, res.delay, res.dirs, pulses};

    msg_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_beat   (beat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (m_beat)
    );

    assign m_tdata = m_beat.data;
    assign m_tlast = m_beat.last;

endmodule

[sv/msg_axis_lane.sv]
// One axis lane: position, delta and Bresenham accumulator of a single axis.
`timescale 1ns / 1ps

module msg_axis_lane
    import msg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lane_cmd_t             cmd,
    input  logic [IN_BITS-1:0]    target,
    input  logic                  dir_bit,
    input  logic [DELTA_BITS-1:0] total,
    input  logic [DELTA_BITS-1:0] seed,
    output lane_stat_t            stat
);

    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [DELTA_BITS-1:0] absd_reg, absd_next;
    logic [ACC_BITS-1:0]   acc_reg, acc_next;

    logic [CALC_BITS-1:0]  t_ext;
    logic [CALC_BITS-1:0]  pos_ext;
    logic [CALC_BITS-1:0]  tgt;
    logic [CALC_BITS-1:0]  delta;
    logic [CALC_BITS-1:0]  absd_wide;
    logic [CALC_BITS-POS_BITS:0] tgt_top;
    logic [CALC_BITS-POS_BITS:0] t_top;
    logic                  tgt_fits;
    logic                  t_fits;
    logic [ACC_BITS-1:0]   acc_sum;
    logic                  pulse;

    assign t_ext   = {{(CALC_BITS-IN_BITS){target[IN_BITS-1]}}, target};
    assign pos_ext = {{(CALC_BITS-POS_BITS){pos_reg[POS_BITS-1]}}, pos_reg};
    assign tgt     = cmd.abs_mode ? t_ext : pos_ext + t_ext;
    assign tgt_top = tgt[CALC_BITS-1:POS_BITS-1];
    assign t_top   = t_ext[CALC_BITS-1:POS_BITS-1];
    assign tgt_fits = (&tgt_top) || !(|tgt_top);
    assign t_fits   = (&t_top) || !(|t_top);
    assign delta     = tgt - pos_ext;
    assign absd_wide = delta[CALC_BITS-1] ? (~delta + CALC_BITS'(1)) : delta;

    assign acc_sum = acc_reg + {1'b0, absd_reg};
    assign pulse   = acc_sum >= {1'b0, total};

    assign stat.ok_move   = tgt_fits && !(|absd_wide[CALC_BITS-1:DELTA_BITS]);
    assign stat.ok_set    = t_fits;
    assign stat.dir_pos   = !delta[CALC_BITS-1] && (|delta);
    assign stat.abs_delta = absd_wide[DELTA_BITS-1:0];
    assign stat.pulse     = cmd.do_tick && pulse;

    always_comb
    begin
        pos_next  = pos_reg;
        absd_next = absd_reg;
        acc_next  = acc_reg;
        if (cmd.do_move)
        begin
            absd_next = absd_wide[DELTA_BITS-1:0];
            acc_next  = {1'b0, seed};
        end
        else if (cmd.do_tick)
        begin
            if (pulse)
            begin
                acc_next = acc_sum - {1'b0, total};
                pos_next = dir_bit ? pos_reg + POS_BITS'(1) : pos_reg - POS_BITS'(1);
            end
            else
            begin
                acc_next = acc_sum;
            end
        end
        else if (cmd.do_set)
        begin
            pos_next = t_ext[POS_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            absd_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            absd_reg <= absd_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

[sv/msg_merge.sv]
// Merge stage: step count, direction bits, ramp plan and delay of the move.
`timescale 1ns / 1ps

module msg_merge
    import msg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  do_move,
    input  logic                  do_tick,
    input  lane_stat_t            stat [AXES],
    input  logic [DELAY_BITS-1:0] start_delay,
    input  logic [DELAY_BITS-1:0] cruise_delay,
    output logic                  active,
    output logic [AXES-1:0]       dirs,
    output logic [DELTA_BITS-1:0] total,
    output logic [DELTA_BITS-1:0] seed,
    output merge_res_t            res
);

    logic [AXES-1:0]       dirs_reg, dirs_next;
    logic [DELTA_BITS-1:0] total_reg, total_next;
    logic [DELTA_BITS-1:0] idx_reg, idx_next;
    logic [DELTA_BITS-1:0] accel_reg, accel_next;
    logic [DELTA_BITS:0]   decel_reg, decel_next;
    logic [DELAY_BITS-1:0] delay_reg, delay_next;
    logic                  active_reg, active_next;

    logic [DELTA_BITS-1:0] maxs;
    logic [AXES-1:0]       dir_pos;
    logic [DELTA_BITS-1:0] half;
    logic [DELAY_BITS-1:0] ramp_raw;
    logic [DELTA_BITS-1:0] ramp;
    logic [DELAY_BITS-1:0] tick_delay;
    logic [DELTA_BITS-1:0] idx_inc;
    logic                  tick_last;

    always_comb
    begin
        maxs = '0;
        for (int i = 0; i < AXES; i++)
        begin
            dir_pos[i] = stat[i].dir_pos;
            if (stat[i].abs_delta > maxs)
            begin
                maxs = stat[i].abs_delta;
            end
        end
    end

    assign half     = maxs >> 1;
    assign ramp_raw = (start_delay > cruise_delay) ? start_delay - cruise_delay : '0;
    assign ramp     = ({{(DELTA_BITS-DELAY_BITS){1'b0}}, ramp_raw} > half) ? half
                      : {{(DELTA_BITS-DELAY_BITS){1'b0}}, ramp_raw};

    always_comb
    begin
        tick_delay = delay_reg;
        if ((idx_reg < accel_reg) && (tick_delay != '0))
        begin
            tick_delay = tick_delay - DELAY_BITS'(1);
        end
        if (({1'b0, idx_reg} >= decel_reg) && (tick_delay != DELAY_MAX))
        begin
            tick_delay = tick_delay + DELAY_BITS'(1);
        end
    end

    assign idx_inc   = idx_reg + DELTA_BITS'(1);
    assign tick_last = idx_inc >= total_reg;

    always_comb
    begin
        dirs_next   = dirs_reg;
        total_next  = total_reg;
        idx_next    = idx_reg;
        accel_next  = accel_reg;
        decel_next  = decel_reg;
        delay_next  = delay_reg;
        active_next = active_reg;
        if (do_move)
        begin
            dirs_next   = dir_pos;
            total_next  = maxs;
            idx_next    = '0;
            accel_next  = ramp;
            decel_next  = {1'b0, maxs} - {1'b0, ramp};
            delay_next  = start_delay;
            active_next = |maxs;
        end
        else if (do_tick)
        begin
            delay_next  = tick_delay;
            idx_next    = idx_inc;
            active_next = !tick_last;
        end
    end

    always_comb
    begin
        res.dirs  = dirs_next;
        res.idle  = !active_next;
        res.delay = '0;
        res.last  = 1'b0;
        if (do_move)
        begin
            res.delay = start_delay;
            res.last  = !(|maxs);
        end
        else if (do_tick)
        begin
            res.delay = tick_delay;
            res.last  = tick_last;
        end
    end

    assign active = active_reg;
    assign dirs   = dirs_reg;
    assign total  = total_reg;
    assign seed   = half;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirs_reg   <= '0;
            total_reg  <= '0;
            idx_reg    <= '0;
            accel_reg  <= '0;
            decel_reg  <= '0;
            delay_reg  <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            dirs_reg   <= dirs_next;
            total_reg  <= total_next;
            idx_reg    <= idx_next;
            accel_reg  <= accel_next;
            decel_reg  <= decel_next;
            delay_reg  <= delay_next;
            active_reg <= active_next;
        end
    end

endmodule

[sv/msg_out_buf.sv]
// Two-entry output buffer: an output register backed by a skid register.
`timescale 1ns / 1ps

module msg_out_buf
    import msg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  out_beat_t in_beat,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_beat
);

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_beat_t out_beat_reg, out_beat_next;
    out_beat_t skid_beat_reg, skid_beat_next;
    logic      push;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_beat_next   = out_beat_reg;
        skid_beat_next  = skid_beat_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_beat_next   = skid_beat_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_beat_next  = in_beat;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_beat_next  = in_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_beat_reg  <= out_beat_next;
        skid_beat_reg <= skid_beat_next;
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

endmodule

[sim/multi_axis_step_generator_tb.sv]
// Self-checking testbench for the three-axis step pulse generator.
`timescale 1ns / 1ps

module multi_axis_step_generator_tb;
    import msg_pkg::*;

    localparam longint POS_HALF    = longint'(1) << (POS_BITS - 1);
    localparam longint DELTA_LIMIT = (longint'(1) << DELTA_BITS) - 1;
    localparam int     PHASES      = 8;
    localparam int     PHASE_BEATS = 165;

    typedef struct packed {
        logic [2:0]  steps;
        logic [2:0]  dirs;
        logic [15:0] delay;
        logic        last_step;
        logic        idle;
        logic        rejected;
    } step_result_t;

    typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        op_t                       op;
        logic [2:0][IN_BITS-1:0]   tgt;
        logic                      typed;
        step_result_t              want;
        logic [CFG_IDX_BITS-1:0]   reg_index;
        logic [DELAY_BITS-1:0]     reg_value;
    } drill_row_t;

    localparam step_result_t NOT_TYPED = '0;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = CFG_MODE;
    logic [DELAY_BITS-1:0]   cfg_data = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata = '0;
    logic [1:0]              s_tuser = OP_TICK;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    m_tlast;

    multi_axis_step_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // Stepper state as the block should hold it.
    logic                       abs_mode_q;
    logic [DELAY_BITS-1:0]      start_q;
    logic [DELAY_BITS-1:0]      cruise_q;
    logic signed [POS_BITS-1:0] pos_q [AXES];
    logic [DELTA_BITS-1:0]      absd_q [AXES];
    logic [ACC_BITS-1:0]        acc_q [AXES];
    logic [AXES-1:0]            dirs_q;
    logic [DELTA_BITS-1:0]      total_q;
    logic [DELTA_BITS-1:0]      index_q;
    logic [DELTA_BITS-1:0]      accel_q;
    logic [ACC_BITS-1:0]        decel_q;
    logic [DELAY_BITS-1:0]      cur_q;
    logic                       active_q;

    step_result_t due_pulses [$];
    int           fail_count = 0;
    int           rx_hold = 0;
    int           rx_odds = 0;
    int           tx_odds = 0;
    bit           calm = 1'b0;
    step_result_t seen_beat;
    step_result_t want_beat;
    drill_row_t   drill [$];

    function automatic step_result_t res(input logic [2:0] steps, input logic [2:0] dirs,
                                         input logic [15:0] delay, input logic last_step,
                                         input logic idle, input logic rejected);
        step_result_t r;
        r.steps     = steps;
        r.dirs      = dirs;
        r.delay     = delay;
        r.last_step = last_step;
        r.idle      = idle;
        r.rejected  = rejected;
        return r;
    endfunction

    function automatic drill_row_t beat_row(input op_t op, input logic [23:0] x,
                                            input logic [23:0] z, input logic [23:0] a,
                                            input logic typed, input step_result_t want);
        drill_row_t row;
        row.kind      = ROW_BEAT;
        row.op        = op;
        row.tgt       = {a, z, x};
        row.typed     = typed;
        row.want      = want;
        row.reg_index = CFG_MODE;
        row.reg_value = '0;
        return row;
    endfunction

    function automatic drill_row_t reg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                           input logic [DELAY_BITS-1:0] val);
        drill_row_t row;
        row           = beat_row(OP_NOP, '0, '0, '0, 1'b0, NOT_TYPED);
        row.kind      = ROW_REG;
        row.reg_index = idx;
        row.reg_value = val;
        return row;
    endfunction

    function automatic bit pos_fits(input longint v);
        return v >= -POS_HALF && v < POS_HALF;
    endfunction

    // Checks a move against the current position and mode; span is the step count.
    function automatic logic move_fits(input logic [2:0][IN_BITS-1:0] tgt,
                                       output logic [DELTA_BITS-1:0] span);
        longint tv;
        longint dst;
        longint dlt;
        int     i;
        span = '0;
        for (i = 0; i < AXES; i++) begin
            tv  = $signed(tgt[i]);
            dst = abs_mode_q ? tv : longint'(pos_q[i]) + tv;
            if (!pos_fits(dst))
                return 1'b0;
            dlt = dst - longint'(pos_q[i]);
            if (dlt < 0)
                dlt = -dlt;
            if (dlt > DELTA_LIMIT)
                return 1'b0;
            if (dlt > longint'(span))
                span = DELTA_BITS'(dlt);
        end
        return 1'b1;
    endfunction

    task automatic reset_stepper();
        int i;
        abs_mode_q = MODE_RESET;
        start_q    = START_RESET;
        cruise_q   = CRUISE_RESET;
        for (i = 0; i < AXES; i++) begin
            pos_q[i]  = '0;
            absd_q[i] = '0;
            acc_q[i]  = '0;
        end
        dirs_q   = '0;
        total_q  = '0;
        index_q  = '0;
        accel_q  = '0;
        decel_q  = '0;
        cur_q    = '0;
        active_q = 1'b0;
    endtask

    task automatic advance_stepper(input op_t op, input logic [2:0][IN_BITS-1:0] tgt,
                                   output step_result_t r);
        logic [DELTA_BITS-1:0] span;
        longint                tv;
        longint                dlt;
        longint                ramp;
        int                    i;
        r = '0;
        case (op)
            OP_MOVE: begin
                if (active_q || !move_fits(tgt, span)) begin
                    r.rejected = 1'b1;
                end else begin
                    for (i = 0; i < AXES; i++) begin
                        tv  = $signed(tgt[i]);
                        dlt = (abs_mode_q ? tv : longint'(pos_q[i]) + tv) - longint'(pos_q[i]);
                        dirs_q[i] = dlt > 0;
                        absd_q[i] = DELTA_BITS'(dlt < 0 ? -dlt : dlt);
                        acc_q[i]  = ACC_BITS'(span >> 1);
                    end
                    total_q = span;
                    index_q = '0;
                    ramp = longint'(start_q) - longint'(cruise_q);
                    if (ramp < 0)
                        ramp = 0;
                    if (ramp > longint'(span >> 1))
                        ramp = longint'(span >> 1);
                    accel_q     = DELTA_BITS'(ramp);
                    decel_q     = ACC_BITS'(span) - ACC_BITS'(ramp);
                    cur_q       = start_q;
                    active_q    = span != 0;
                    r.delay     = start_q;
                    r.last_step = span == 0;
                end
            end
            OP_TICK: begin
                if (active_q) begin
                    for (i = 0; i < AXES; i++) begin
                        acc_q[i] = acc_q[i] + ACC_BITS'(absd_q[i]);
                        if (acc_q[i] >= ACC_BITS'(total_q)) begin
                            acc_q[i]   = acc_q[i] - ACC_BITS'(total_q);
                            r.steps[i] = 1'b1;
                            pos_q[i]   = dirs_q[i] ? pos_q[i] + 1 : pos_q[i] - 1;
                        end
                    end
                    if (index_q < accel_q && cur_q > 0)
                        cur_q = cur_q - 1'b1;
                    if (ACC_BITS'(index_q) >= decel_q && cur_q < DELAY_MAX)
                        cur_q = cur_q + 1'b1;
                    r.delay = cur_q;
                    index_q = index_q + 1'b1;
                    if (index_q >= total_q) begin
                        r.last_step = 1'b1;
                        active_q    = 1'b0;
                    end
                end
            end
            OP_SETPOS: begin
                if (active_q) begin
                    r.rejected = 1'b1;
                end else begin
                    for (i = 0; i < AXES; i++)
                        pos_q[i] = $signed(tgt[i]);
                end
            end
            default: ;
        endcase
        r.dirs = dirs_q;
        r.idle = !active_q;
    endtask

    task automatic send_beat(input op_t op, input logic [2:0][IN_BITS-1:0] tgt,
                             input logic typed, input step_result_t want);
        step_result_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= tgt;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        advance_stepper(op, tgt, r);
        due_pulses.push_back(typed ? want : r);
        if (!calm && tx_odds != 0 && $urandom_range(0, tx_odds) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10))
                @(posedge clk);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (due_pulses.size() != 0)
            @(posedge clk);
        repeat (2)
            @(posedge clk);
    endtask

    task automatic finish_move();
        while (active_q)
            send_beat(OP_TICK, '0, 1'b0, NOT_TYPED);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [DELAY_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_MODE:   abs_mode_q = val[0];
            CFG_START:  start_q    = val;
            CFG_CRUISE: cruise_q   = val;
            default: ;
        endcase
    endtask

    function automatic logic [2:0][IN_BITS-1:0] small_move(input int cap);
        logic [2:0][IN_BITS-1:0] tgt;
        int                      lim;
        longint                  off;
        longint                  dst;
        int                      i;
        lim = $urandom_range(0, cap);
        for (i = 0; i < AXES; i++) begin
            off = longint'($urandom_range(0, 2 * lim)) - lim;
            dst = longint'(pos_q[i]) + off;
            if (!pos_fits(dst)) begin
                off = -off;
                dst = longint'(pos_q[i]) + off;
            end
            tgt[i] = IN_BITS'(abs_mode_q ? dst : off);
        end
        return tgt;
    endfunction

    function automatic logic [2:0][IN_BITS-1:0] new_position(input int cap);
        logic [2:0][IN_BITS-1:0] tgt;
        int                      i;
        for (i = 0; i < AXES; i++) begin
            case ($urandom_range(0, 3))
                0:       tgt[i] = IN_BITS'(POS_HALF - 1 - $urandom_range(0, cap));
                1:       tgt[i] = IN_BITS'(-POS_HALF + $urandom_range(0, cap));
                2:       tgt[i] = IN_BITS'(longint'($urandom_range(0, 2 * cap)) - cap);
                default: tgt[i] = IN_BITS'($urandom);
            endcase
        end
        return tgt;
    endfunction

    task automatic random_beat(input int cap, inout int counted);
        logic [2:0][IN_BITS-1:0] tgt;
        logic [DELTA_BITS-1:0]   span;
        int                      pick;
        int                      i;
        pick = $urandom_range(0, 99);
        for (i = 0; i < AXES; i++)
            tgt[i] = IN_BITS'($urandom);
        if (!active_q) begin
            if (pick < 10) begin
                if (move_fits(tgt, span) && span > cap)
                    tgt = small_move(cap);
                send_beat(OP_MOVE, tgt, 1'b0, NOT_TYPED);
                counted++;
            end else if (pick < 68) begin
                send_beat(OP_MOVE, small_move(cap), 1'b0, NOT_TYPED);
                counted++;
            end else if (pick < 85) begin
                send_beat(OP_SETPOS, new_position(cap), 1'b0, NOT_TYPED);
                counted++;
            end else if (pick < 93) begin
                send_beat(OP_TICK, tgt, 1'b0, NOT_TYPED);
            end else begin
                send_beat(OP_NOP, tgt, 1'b0, NOT_TYPED);
            end
        end else begin
            if (pick < 86)
                send_beat(OP_TICK, tgt, 1'b0, NOT_TYPED);
            else if (pick < 92)
                send_beat(OP_MOVE, tgt, 1'b0, NOT_TYPED);
            else if (pick < 97)
                send_beat(OP_SETPOS, tgt, 1'b0, NOT_TYPED);
            else
                send_beat(OP_NOP, tgt, 1'b0, NOT_TYPED);
            if (pick < 97)
                counted++;
        end
    endtask

    function automatic int field_bad(input string name, input longint want, input longint got);
        if (want == got)
            return 0;
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        return 1;
    endfunction

    always @(posedge clk)
    begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_odds != 0 && $urandom_range(0, rx_odds) == 0) begin
            rx_hold  <= $urandom_range(0, 9);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) begin
            seen_beat.steps     = m_tdata[2:0];
            seen_beat.dirs      = m_tdata[5:3];
            seen_beat.delay     = m_tdata[21:6];
            seen_beat.idle      = m_tdata[22];
            seen_beat.rejected  = m_tdata[23];
            seen_beat.last_step = m_tlast;
            if (due_pulses.size() == 0) begin
                $error("result beat arrived with nothing expected");
                fail_count++;
            end else begin
                want_beat = due_pulses.pop_front();
                fail_count += field_bad("step_x", want_beat.steps[0], seen_beat.steps[0]);
                fail_count += field_bad("step_z", want_beat.steps[1], seen_beat.steps[1]);
                fail_count += field_bad("step_a", want_beat.steps[2], seen_beat.steps[2]);
                fail_count += field_bad("dir_x", want_beat.dirs[0], seen_beat.dirs[0]);
                fail_count += field_bad("dir_z", want_beat.dirs[1], seen_beat.dirs[1]);
                fail_count += field_bad("dir_a", want_beat.dirs[2], seen_beat.dirs[2]);
                fail_count += field_bad("interval_delay", want_beat.delay, seen_beat.delay);
                fail_count += field_bad("last_step", want_beat.last_step, seen_beat.last_step);
                fail_count += field_bad("idle", want_beat.idle, seen_beat.idle);
                fail_count += field_bad("rejected", want_beat.rejected, seen_beat.rejected);
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int                    odds_set [3];
        int                    counted;
        int                    cap;
        int                    k;
        int                    ph;
        bit                    paused;
        logic                  mode_v;
        logic [DELAY_BITS-1:0] start_v;
        logic [DELAY_BITS-1:0] cruise_v;

        odds_set = '{0, 2, 6};
        reset_stepper();

        drill.push_back(beat_row(OP_TICK, 24'h000000, 24'h000000, 24'h000000, 1'b1,
                                 res(3'b000, 3'b000, 16'd0, 1'b0, 1'b1, 1'b0)));
        drill.push_back(beat_row(OP_NOP, 24'hffffff, 24'h800000, 24'h7fffff, 1'b1,
                                 res(3'b000, 3'b000, 16'd0, 1'b0, 1'b1, 1'b0)));
        drill.push_back(beat_row(OP_SETPOS, 24'h7fffff, 24'h800000, 24'h000000, 1'b1,
                                 res(3'b000, 3'b000, 16'd0, 1'b0, 1'b1, 1'b0)));
        drill.push_back(beat_row(OP_MOVE, 24'h7fffff, 24'h800000, 24'h000000, 1'b1,
                                 res(3'b000, 3'b000, 16'd1000, 1'b1, 1'b1, 1'b0)));
        drill.push_back(beat_row(OP_SETPOS, 24'h7ffff8, 24'h800008, 24'h000000, 1'b1,
                                 res(3'b000, 3'b000, 16'd0, 1'b0, 1'b1, 1'b0)));
        drill.push_back(beat_row(OP_MOVE, 24'h7fffff, 24'h800000, 24'h000003, 1'b1,
                                 res(3'b000, 3'b101, 16'd1000, 1'b0, 1'b0, 1'b0)));
        drill.push_back(beat_row(OP_MOVE, 24'h000000, 24'hffffff, 24'h555555, 1'b1,
                                 res(3'b000, 3'b101, 16'd0, 1'b0, 1'b0, 1'b1)));
        drill.push_back(beat_row(OP_SETPOS, 24'haaaaaa, 24'h000000, 24'hffffff, 1'b1,
                                 res(3'b000, 3'b101, 16'd0, 1'b0, 1'b0, 1'b1)));
        drill.push_back(beat_row(OP_NOP, 24'h123456, 24'h654321, 24'h0f0f0f, 1'b1,
                                 res(3'b000, 3'b101, 16'd0, 1'b0, 1'b0, 1'b0)));
        for (k = 0; k < 8; k++)
            drill.push_back(beat_row(OP_TICK, '0, '0, '0, 1'b0, NOT_TYPED));
        drill.push_back(reg_row(CFG_MODE, 16'd0));
        drill.push_back(beat_row(OP_MOVE, 24'h000001, 24'hffffff, 24'h000000, 1'b1,
                                 res(3'b000, 3'b101, 16'd0, 1'b0, 1'b1, 1'b1)));
        drill.push_back(beat_row(OP_MOVE, 24'hfffffe, 24'h000002, 24'h000000, 1'b0,
                                 NOT_TYPED));
        drill.push_back(beat_row(OP_TICK, '0, '0, '0, 1'b0, NOT_TYPED));
        drill.push_back(beat_row(OP_TICK, '0, '0, '0, 1'b0, NOT_TYPED));
        drill.push_back(reg_row(CFG_START, 16'hffff));
        drill.push_back(reg_row(CFG_CRUISE, 16'd1));
        drill.push_back(beat_row(OP_MOVE, 24'h000005, 24'hfffffd, 24'h000000, 1'b0,
                                 NOT_TYPED));
        for (k = 0; k < 3; k++)
            drill.push_back(beat_row(OP_TICK, '0, '0, '0, 1'b0, NOT_TYPED));

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (drill[row_k]) begin
            if (drill[row_k].kind == ROW_REG) begin
                finish_move();
                settle();
                write_reg(drill[row_k].reg_index, drill[row_k].reg_value);
            end else begin
                send_beat(drill[row_k].op, drill[row_k].tgt, drill[row_k].typed,
                          drill[row_k].want);
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            finish_move();
            settle();
            case (ph)
                0: begin mode_v = 1'b1; start_v = 16'hffff; cruise_v = 16'd1; end
                1: begin mode_v = 1'b0; start_v = 16'd1; cruise_v = 16'hffff; end
                2: begin mode_v = 1'b1; start_v = 16'd1; cruise_v = 16'd1; end
                3: begin mode_v = 1'b0; start_v = 16'hffff; cruise_v = 16'hffff; end
                4: begin
                    mode_v   = $urandom_range(0, 1);
                    start_v  = $urandom_range(30, 80);
                    cruise_v = $urandom_range(1, 20);
                end
                default: begin
                    mode_v   = $urandom_range(0, 1);
                    start_v  = $urandom_range(1, 65535);
                    cruise_v = $urandom_range(1, 65535);
                    if ($urandom_range(0, 1) == 0)
                        start_v = cruise_v + $urandom_range(0, 40);
                end
            endcase
            write_reg(CFG_MODE, {15'd0, mode_v});
            write_reg(CFG_START, start_v);
            write_reg(CFG_CRUISE, cruise_v);
            calm    = ph == PHASES - 1;
            tx_odds = odds_set[$urandom_range(0, 2)];
            rx_odds = odds_set[$urandom_range(0, 2)];
            cap     = ph == 4 ? 300 : 24;
            counted = 0;
            paused  = 1'b0;
            while (counted < PHASE_BEATS) begin
                random_beat(cap, counted);
                if (!paused && counted >= PHASE_BEATS / 2) begin
                    paused = 1'b1;
                    settle();
                end
            end
        end

        s_tvalid <= 1'b0;
        while (due_pulses.size() != 0)
            @(posedge clk);
        repeat (5)
            @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
